// File: src/assert_macros.svh
// Assertion macros used by the checker file of the header parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPCHP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IPCHP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/ipchp_pkg.sv
// Package with the types, constants and helpers of the IPC command header parser.
package ipchp_pkg;

  localparam int BUFFER_WORDS_DEF = 64;
  localparam int SUM_W = 9;

  localparam logic [31:0] MAGIC_IN = 32'h4943_4653;

  localparam logic [15:0] TYPE_CLOSE       = 16'd2;
  localparam logic [15:0] TYPE_CLOSE_ALT   = 16'd15;
  localparam logic [15:0] TYPE_REQUEST     = 16'd4;
  localparam logic [15:0] TYPE_REQUEST_CTX = 16'd6;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_CLOSE       = 3'd1,
    ST_OVERRUN     = 3'd2,
    ST_UNSUPPORTED = 3'd3,
    ST_BAD_MAGIC   = 3'd4
  } status_e;

  typedef struct packed {
    logic [15:0] desc_counts;
    logic [3:0]  rx_list_flags;
    logic        has_hd;
    logic [9:0]  hd_word;
  } walk_in_t;

  typedef struct packed {
    logic overrun;
  } walk_out_t;

  function automatic logic [2:0] first_handle(input logic has_hd, input logic pid_req);
    first_handle = 3'd2 + {2'b00, has_hd} + {1'b0, pid_req, 1'b0};
  endfunction

endpackage

// File: src/ipchp_desc_walk.sv
// Descriptor walk: sizes the descriptor area, aligns the raw section and checks for overrun.
module ipchp_desc_walk
  import ipchp_pkg::*;
#(
  parameter int BUFFER_WORDS = BUFFER_WORDS_DEF,
  localparam int IDX_W = $clog2(BUFFER_WORDS)
) (
  input  walk_in_t          walk_i,
  output walk_out_t         walk_o,
  output logic [IDX_W-1:0]  raw_start_o
);

  localparam int BW_W  = $clog2(BUFFER_WORDS + 1);
  localparam int CMP_W = ((SUM_W > BW_W) ? SUM_W : BW_W) + 1;

  logic             pid_req;
  logic [3:0]       copy_n;
  logic [3:0]       move_n;
  logic [3:0]       nx;
  logic [3:0]       na;
  logic [3:0]       nb;
  logic [3:0]       nw;
  logic [4:0]       recv_words;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] padded;
  logic [CMP_W-1:0] raw_end;

  always_comb begin
    pid_req = walk_i.has_hd & walk_i.hd_word[0];
    copy_n  = walk_i.has_hd ? walk_i.hd_word[4:1] : 4'd0;
    move_n  = walk_i.has_hd ? walk_i.hd_word[8:5] : 4'd0;
    {nw, nb, na, nx} = walk_i.desc_counts;

    if (walk_i.rx_list_flags == 4'd2) begin
      recv_words = 5'd2;
    end else if (walk_i.rx_list_flags > 4'd2) begin
      recv_words = {walk_i.rx_list_flags - 4'd2, 1'b0};
    end else begin
      recv_words = 5'd0;
    end

    sum = SUM_W'(first_handle(walk_i.has_hd, pid_req))
        + SUM_W'(copy_n) + SUM_W'(move_n)
        + SUM_W'({nx, 1'b0})
        + SUM_W'(3) * (SUM_W'(na) + SUM_W'(nb) + SUM_W'(nw))
        + SUM_W'(recv_words);

    padded  = (sum + SUM_W'(3)) & ~SUM_W'(3);
    raw_end = CMP_W'(padded) + CMP_W'(4);

    walk_o.overrun = raw_end > CMP_W'(BUFFER_WORDS);
    raw_start_o    = IDX_W'(padded);
  end

endmodule

// File: src/ipc_command_header_parser_unit.sv
// Top level of the IPC command header parser: input register, header state and result register.
//
//  Channel   Handshake                  Payload
//  input     in_valid_i / in_stall_o    word_i, start_req_i
//  result    out_valid_o / out_stall_i  status_o .. body_len_o
//
// One word is taken per cycle while in_stall_o is low and passes through the input register.
// The result register loads when the header state takes the word that completes the header.
// Reset leaves the parser idle, ignoring words until one arrives with start_req_i set.
// A stalled result holds the result register, and the input register then holds its word.
module ipc_command_header_parser_unit
  import ipchp_pkg::*;
#(
  parameter int BUFFER_WORDS = BUFFER_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] word_i,
  input  logic        start_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] msg_type_o,
  output logic [31:0] cmd_word_o,
  output logic        pid_req_o,
  output logic [63:0] caller_pid_o,
  output logic [3:0]  copy_hnd_o,
  output logic [3:0]  move_hnd_o,
  output logic [5:0]  handle_offset_o,
  output logic [5:0]  raw_offset_o,
  output logic [5:0]  body_len_o
);

  localparam int IDX_W = $clog2(BUFFER_WORDS);
  localparam logic [IDX_W:0] BW_L = (IDX_W + 1)'(BUFFER_WORDS);

  // Input register.
  logic        s1_valid_q, s1_valid_d;
  logic [31:0] s1_word_q;
  logic        s1_start_q;

  // Header state.
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             done_q, done_d;
  logic [31:0]      hdr0_q, hdr0_d;
  logic             has_hd_q, has_hd_d;
  logic [3:0]       rlf_q, rlf_d;
  logic [9:0]       hdw_q, hdw_d;
  logic [31:0]      pid_lo_q, pid_lo_d;
  logic [31:0]      pid_hi_q, pid_hi_d;
  logic [IDX_W-1:0] raw_q, raw_d;
  logic             magic_q, magic_d;

  // Result register.
  logic        out_valid_q, out_valid_d;
  status_e     out_status_q, out_status_d;
  logic [15:0] out_type_q, out_type_d;
  logic [31:0] out_cmd_q, out_cmd_d;
  logic        out_sp_q, out_sp_d;
  logic [63:0] out_pid_q, out_pid_d;
  logic [3:0]  out_copy_q, out_copy_d;
  logic [3:0]  out_move_q, out_move_d;
  logic [5:0]  out_hoff_q, out_hoff_d;
  logic [5:0]  out_raw_q, out_raw_d;
  logic [5:0]  out_pay_q, out_pay_d;

  logic             out_free;
  logic             fire;
  logic             walk_step;
  logic             final_step;
  logic             emit;
  logic             src_hd;
  logic [9:0]       src_hdw;
  logic             src_sp;
  logic [15:0]      msg_type;
  logic [IDX_W:0]   pay_full;
  walk_in_t         walk_in;
  walk_out_t        walk_out;
  logic [IDX_W-1:0] walk_raw;

  ipchp_desc_walk #(
    .BUFFER_WORDS(BUFFER_WORDS)
  ) u_walk (
    .walk_i      (walk_in),
    .walk_o      (walk_out),
    .raw_start_o (walk_raw)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (!in_stall_o) begin
      s1_valid_d = in_valid_i;
    end

    walk_in.desc_counts   = hdr0_q[31:16];
    walk_in.rx_list_flags = (idx_q == IDX_W'(1)) ? s1_word_q[13:10] : rlf_q;
    walk_in.has_hd        = (idx_q != IDX_W'(1));
    walk_in.hd_word       = s1_word_q[9:0];

    idx_d    = idx_q;
    done_d   = done_q;
    hdr0_d   = hdr0_q;
    has_hd_d = has_hd_q;
    rlf_d    = rlf_q;
    hdw_d    = hdw_q;
    pid_lo_d = pid_lo_q;
    pid_hi_d = pid_hi_q;
    raw_d    = raw_q;
    magic_d  = magic_q;

    walk_step  = 1'b0;
    final_step = 1'b0;

    if (fire) begin
      if (s1_start_q) begin
        idx_d    = IDX_W'(1);
        done_d   = 1'b0;
        hdr0_d   = s1_word_q;
        has_hd_d = 1'b0;
        rlf_d    = 4'd0;
        hdw_d    = 10'd0;
        pid_lo_d = 32'd0;
        pid_hi_d = 32'd0;
        raw_d    = '0;
        magic_d  = 1'b0;
      end else if (!done_q) begin
        idx_d = idx_q + IDX_W'(1);
        if (idx_q == IDX_W'(0)) begin
          hdr0_d = s1_word_q;
        end else if (idx_q == IDX_W'(1)) begin
          rlf_d    = s1_word_q[13:10];
          has_hd_d = s1_word_q[31];
          walk_step = !s1_word_q[31];
        end else if (idx_q == IDX_W'(2) && has_hd_q) begin
          hdw_d     = s1_word_q[9:0];
          walk_step = 1'b1;
        end else begin
          if (has_hd_q && hdw_q[0] && idx_q == IDX_W'(3)) begin
            pid_lo_d = s1_word_q;
          end
          if (has_hd_q && hdw_q[0] && idx_q == IDX_W'(4)) begin
            pid_hi_d = s1_word_q;
          end
          if (idx_q == raw_q) begin
            magic_d = (s1_word_q == MAGIC_IN);
          end
          final_step = (idx_q == raw_q + IDX_W'(2));
        end
        if (walk_step) begin
          raw_d = walk_raw;
        end
      end
    end

    emit = (walk_step && walk_out.overrun) || final_step;
    if (emit) begin
      done_d = 1'b1;
    end

    src_hd   = walk_step ? walk_in.has_hd : has_hd_q;
    src_hdw  = walk_step ? walk_in.hd_word : hdw_q;
    src_sp   = src_hd & src_hdw[0];
    msg_type = hdr0_q[15:0];
    pay_full = BW_L - {1'b0, raw_q} - (IDX_W + 1)'(4);

    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_type_d   = out_type_q;
    out_cmd_d    = out_cmd_q;
    out_sp_d     = out_sp_q;
    out_pid_d    = out_pid_q;
    out_copy_d   = out_copy_q;
    out_move_d   = out_move_q;
    out_hoff_d   = out_hoff_q;
    out_raw_d    = out_raw_q;
    out_pay_d    = out_pay_q;

    if (out_free) begin
      out_valid_d = emit;
    end

    if (emit) begin
      out_type_d = msg_type;
      out_sp_d   = src_sp;
      out_copy_d = src_hd ? src_hdw[4:1] : 4'd0;
      out_move_d = src_hd ? src_hdw[8:5] : 4'd0;
      out_hoff_d = 6'(first_handle(src_hd, src_sp));
      if (walk_step) begin
        out_status_d = ST_OVERRUN;
        out_cmd_d    = 32'd0;
        out_pid_d    = 64'd0;
        out_raw_d    = 6'd0;
        out_pay_d    = 6'd0;
      end else begin
        out_cmd_d = 32'd0;
        out_pid_d = src_sp ? {pid_hi_q, pid_lo_q} : 64'd0;
        out_raw_d = 6'(raw_q);
        out_pay_d = 6'(pay_full);
        if (msg_type == TYPE_CLOSE || msg_type == TYPE_CLOSE_ALT) begin
          out_status_d = ST_CLOSE;
        end else if (msg_type != TYPE_REQUEST && msg_type != TYPE_REQUEST_CTX) begin
          out_status_d = ST_UNSUPPORTED;
        end else if (!magic_q) begin
          out_status_d = ST_BAD_MAGIC;
        end else begin
          out_status_d = ST_OK;
          out_cmd_d    = s1_word_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      idx_q       <= '0;
      done_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      idx_q       <= idx_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      s1_word_q  <= word_i;
      s1_start_q <= start_req_i;
    end
    hdr0_q       <= hdr0_d;
    has_hd_q     <= has_hd_d;
    rlf_q        <= rlf_d;
    hdw_q        <= hdw_d;
    pid_lo_q     <= pid_lo_d;
    pid_hi_q     <= pid_hi_d;
    raw_q        <= raw_d;
    magic_q      <= magic_d;
    out_status_q <= out_status_d;
    out_type_q   <= out_type_d;
    out_cmd_q    <= out_cmd_d;
    out_sp_q     <= out_sp_d;
    out_pid_q    <= out_pid_d;
    out_copy_q   <= out_copy_d;
    out_move_q   <= out_move_d;
    out_hoff_q   <= out_hoff_d;
    out_raw_q    <= out_raw_d;
    out_pay_q    <= out_pay_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign msg_type_o      = out_type_q;
  assign cmd_word_o      = out_cmd_q;
  assign pid_req_o       = out_sp_q;
  assign caller_pid_o    = out_pid_q;
  assign copy_hnd_o      = out_copy_q;
  assign move_hnd_o      = out_move_q;
  assign handle_offset_o = out_hoff_q;
  assign raw_offset_o    = out_raw_q;
  assign body_len_o      = out_pay_q;

endmodule

// File: src/ipchp_checker.sv
// Port-level checker for the IPC command header parser and its bind to the top level.
`include "assert_macros.svh"

module ipchp_checker
  import ipchp_pkg::*;
#(
  parameter int BUFFER_WORDS = BUFFER_WORDS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [31:0] cmd_word_o,
  input logic        pid_req_o,
  input logic [63:0] caller_pid_o,
  input logic [5:0]  raw_offset_o,
  input logic [5:0]  body_len_o
);

  localparam logic [5:0] BW_MOD = 6'(BUFFER_WORDS);

  logic       ovr_seen;
  logic       ovr_clear;
  logic       layout_ok;
  logic [5:0] raw_end;

  assign ovr_seen  = out_valid_o && status_o == ST_OVERRUN;
  assign ovr_clear = caller_pid_o == 64'd0 && raw_offset_o == 6'd0 && body_len_o == 6'd0;
  assign raw_end   = raw_offset_o + body_len_o + 6'd4;
  assign layout_ok = raw_offset_o[1:0] == 2'b00 && raw_end == BW_MOD;

  `IPCHP_ASSERT_NXT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  `IPCHP_ASSERT_IMP(a_overrun_zero, clk_i, rst_ni, ovr_seen, ovr_clear)

  `IPCHP_ASSERT_IMP(a_cmd_only_ok, clk_i, rst_ni, out_valid_o && status_o != ST_OK, cmd_word_o == 32'd0)

  `IPCHP_ASSERT_IMP(a_raw_layout, clk_i, rst_ni, out_valid_o && !ovr_seen, layout_ok)

  `IPCHP_ASSERT_IMP(a_pid_needs_flag, clk_i, rst_ni, out_valid_o && !pid_req_o, caller_pid_o == 64'd0)

endmodule

bind ipc_command_header_parser_unit ipchp_checker #(
  .BUFFER_WORDS(BUFFER_WORDS)
) u_ipchp_checker (.*);

// File: verif/tb.sv
// Testbench for the IPC command header parser: directed and random command buffers, checked per field.
`timescale 1ns / 1ps

module tb
  import ipchp_pkg::*;
();

  localparam int BUF_WORDS = BUFFER_WORDS_DEF;
  localparam int unsigned ITEM_TARGET = 1750;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 400_000;

  typedef struct packed {
    status_e     status;
    logic [15:0] msg_type;
    logic [31:0] cmd_word;
    logic        pid_req;
    logic [63:0] caller_pid;
    logic [3:0]  copy_hnd;
    logic [3:0]  move_hnd;
    logic [5:0]  handle_offset;
    logic [5:0]  raw_offset;
    logic [5:0]  body_len;
  } header_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] word_i;
  logic        start_req_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  status_o;
  logic [15:0] msg_type_o;
  logic [31:0] cmd_word_o;
  logic        pid_req_o;
  logic [63:0] caller_pid_o;
  logic [3:0]  copy_hnd_o;
  logic [3:0]  move_hnd_o;
  logic [5:0]  handle_offset_o;
  logic [5:0]  raw_offset_o;
  logic [5:0]  body_len_o;

  header_t     headers_due[$];
  logic [31:0] buf_words[BUF_WORDS];
  int unsigned errors = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_words = 0;
  int unsigned hold_req = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;

  // Parser state as the predictor sees it.
  int unsigned word_pos = 0;
  bit          idle = 1'b1;
  logic [31:0] hdr_w0 = '0;
  bit          hd_present = 1'b0;
  logic [3:0]  rx_flags = '0;
  logic [9:0]  hd_bits = '0;
  logic [31:0] pid_lo = '0;
  logic [31:0] pid_hi = '0;
  int unsigned raw_at = 0;
  bit          magic_seen = 1'b0;

  ipc_command_header_parser_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .word_i          (word_i),
    .start_req_i     (start_req_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .msg_type_o      (msg_type_o),
    .cmd_word_o      (cmd_word_o),
    .pid_req_o       (pid_req_o),
    .caller_pid_o    (caller_pid_o),
    .copy_hnd_o      (copy_hnd_o),
    .move_hnd_o      (move_hnd_o),
    .handle_offset_o (handle_offset_o),
    .raw_offset_o    (raw_offset_o),
    .body_len_o      (body_len_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic bit walk_layout(input logic [31:0] w0, input logic [3:0] flags,
                                     input bit with_hd, input logic [9:0] hd,
                                     output int unsigned raw);
    int unsigned idx, nx, na, nb, nw, fl;
    raw = 0;
    nx = w0[19:16];
    na = w0[23:20];
    nb = w0[27:24];
    nw = w0[31:28];
    fl = flags;
    idx = 2 + (with_hd ? 1 : 0) + ((with_hd && hd[0]) ? 2 : 0);
    if (idx > BUF_WORDS) return 1'b0;
    if (with_hd) idx += hd[4:1];
    if (idx > BUF_WORDS) return 1'b0;
    if (with_hd) idx += hd[8:5];
    if (idx > BUF_WORDS) return 1'b0;
    idx += 2 * nx + 3 * (na + nb + nw);
    if (fl >= 2) idx += (fl == 2) ? 2 : 2 * (fl - 2);
    if (idx > BUF_WORDS) return 1'b0;
    idx = (idx + 3) & ~32'd3;
    if (idx + 4 > BUF_WORDS) return 1'b0;
    raw = idx;
    return 1'b1;
  endfunction

  function automatic header_t make_header(input status_e st, input logic [31:0] cmd,
                                          input bit walked);
    header_t h;
    bit sp;
    sp = hd_present & hd_bits[0];
    h.status = st;
    h.msg_type = hdr_w0[15:0];
    h.cmd_word = cmd;
    h.pid_req = sp;
    h.caller_pid = (walked && sp) ? {pid_hi, pid_lo} : 64'd0;
    h.copy_hnd = hd_present ? hd_bits[4:1] : 4'd0;
    h.move_hnd = hd_present ? hd_bits[8:5] : 4'd0;
    h.handle_offset = 6'(2 + int'(hd_present) + 2 * int'(sp));
    h.raw_offset = walked ? 6'(raw_at) : 6'd0;
    h.body_len = walked ? 6'(BUF_WORDS - raw_at - 4) : 6'd0;
    idle = 1'b1;
    return h;
  endfunction

  function automatic bit parse_word(input logic [31:0] w, input logic s, output header_t hdr);
    bit emitted, sp;
    logic [15:0] mtype;
    hdr = '0;
    emitted = 1'b0;
    if (s) begin
      word_pos = 0;
      idle = 1'b0;
      hdr_w0 = '0;
      hd_present = 1'b0;
      rx_flags = '0;
      hd_bits = '0;
      pid_lo = '0;
      pid_hi = '0;
      raw_at = 0;
      magic_seen = 1'b0;
    end
    if (idle) return 1'b0;
    if (word_pos == 0) begin
      hdr_w0 = w;
    end else if (word_pos == 1) begin
      rx_flags = w[13:10];
      hd_present = w[31];
      if (!hd_present) begin
        if (!walk_layout(hdr_w0, rx_flags, 1'b0, hd_bits, raw_at)) begin
          hdr = make_header(ST_OVERRUN, '0, 1'b0);
          emitted = 1'b1;
        end
      end
    end else if (word_pos == 2 && hd_present) begin
      hd_bits = w[9:0];
      if (!walk_layout(hdr_w0, rx_flags, 1'b1, hd_bits, raw_at)) begin
        hdr = make_header(ST_OVERRUN, '0, 1'b0);
        emitted = 1'b1;
      end
    end else begin
      sp = hd_present & hd_bits[0];
      if (sp && word_pos == 3) pid_lo = w;
      if (sp && word_pos == 4) pid_hi = w;
      if (word_pos == raw_at) magic_seen = (w == MAGIC_IN);
      if (word_pos == raw_at + 2) begin
        mtype = hdr_w0[15:0];
        emitted = 1'b1;
        if (mtype == TYPE_CLOSE || mtype == TYPE_CLOSE_ALT) begin
          hdr = make_header(ST_CLOSE, '0, 1'b1);
        end else if (mtype != TYPE_REQUEST && mtype != TYPE_REQUEST_CTX) begin
          hdr = make_header(ST_UNSUPPORTED, '0, 1'b1);
        end else if (!magic_seen) begin
          hdr = make_header(ST_BAD_MAGIC, '0, 1'b1);
        end else begin
          hdr = make_header(ST_OK, w, 1'b1);
        end
      end
    end
    if (word_pos < 511) word_pos++;
    return emitted;
  endfunction

  // Fills the buffer with random words around the given header and returns the index of the
  // word on which the parser should report.
  function automatic int unsigned compose_buffer(input logic [15:0] mtype,
                                                 input logic [15:0] counts,
                                                 input logic [3:0] flags, input bit with_hd,
                                                 input logic [9:0] hd, input bit good_magic);
    int unsigned raw;
    foreach (buf_words[i]) buf_words[i] = $urandom;
    buf_words[0] = {counts, mtype};
    buf_words[1][13:10] = flags;
    buf_words[1][31] = with_hd;
    if (with_hd) buf_words[2][9:0] = hd;
    if (!walk_layout(buf_words[0], flags, with_hd, hd, raw)) return with_hd ? 2 : 1;
    if (good_magic) begin
      buf_words[raw] = MAGIC_IN;
    end else if (buf_words[raw] == MAGIC_IN) begin
      buf_words[raw][0] = ~buf_words[raw][0];
    end
    return raw + 2;
  endfunction

  task automatic send_word(input logic [31:0] w, input logic s);
    int unsigned gap;
    header_t hdr;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    word_i <= w;
    start_req_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_words++;
    if (parse_word(w, s, hdr)) headers_due.push_back(hdr);
  endtask

  task automatic send_buffer(input int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) send_word(buf_words[i], i == 0);
  endtask

  task automatic send_message(input logic [15:0] mtype, input logic [15:0] counts,
                              input logic [3:0] flags, input bit with_hd,
                              input logic [9:0] hd, input bit good_magic);
    int unsigned at;
    at = compose_buffer(mtype, counts, flags, with_hd, hd, good_magic);
    send_buffer(at + 1);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (headers_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_idle_after_reset();
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word($urandom, 1'b0);
    send_message(TYPE_REQUEST, '0, 4'd0, 1'b0, '0, 1'b1);
    settle();
  endtask

  task automatic test_message_types();
    send_message(TYPE_REQUEST, '0, 4'd0, 1'b0, '0, 1'b1);
    send_message(TYPE_REQUEST_CTX, '0, 4'd1, 1'b0, '0, 1'b1);
    send_message(TYPE_CLOSE, '0, 4'd0, 1'b0, '0, 1'b0);
    send_message(TYPE_CLOSE_ALT, '0, 4'd0, 1'b0, '0, 1'b1);
    send_message(16'h0000, '0, 4'd0, 1'b0, '0, 1'b1);
    send_message(16'hFFFF, '0, 4'd0, 1'b0, '0, 1'b1);
    send_message(16'd5, '0, 4'd0, 1'b0, '0, 1'b1);
    send_message(TYPE_REQUEST, '0, 4'd0, 1'b0, '0, 1'b0);
    send_message(16'hFFFF, 16'hFFFF, 4'hF, 1'b1, 10'h3FF, 1'b0);
    settle();
  endtask

  task automatic test_handle_descriptor();
    send_message(TYPE_REQUEST, '0, 4'd0, 1'b1, 10'h1FF, 1'b1);
    send_message(TYPE_REQUEST_CTX, '0, 4'd2, 1'b1, 10'h001, 1'b1);
    send_message(TYPE_REQUEST, '0, 4'hF, 1'b1, 10'h006, 1'b1);
    send_message(TYPE_REQUEST, '0, 4'd0, 1'b1, 10'h200, 1'b1);
    settle();
  endtask

  task automatic test_walk_bounds();
    // The first message ends its raw section exactly at the buffer end; the next one overruns.
    send_message(TYPE_REQUEST, 16'h008F, 4'd3, 1'b0, '0, 1'b1);
    send_message(TYPE_REQUEST, 16'h009F, 4'd3, 1'b0, '0, 1'b1);
    send_message(TYPE_REQUEST, 16'h000F, 4'd0, 1'b1, 10'h1FF, 1'b1);
    send_message(TYPE_REQUEST_CTX, 16'h1111, 4'd1, 1'b0, '0, 1'b1);
    settle();
  endtask

  task automatic test_restart();
    int unsigned at;
    at = compose_buffer(TYPE_REQUEST, '0, 4'd0, 1'b1, 10'h001, 1'b1);
    send_buffer(4);
    send_message(TYPE_REQUEST, '0, 4'd0, 1'b0, '0, 1'b1);
    repeat (3) send_word($urandom, 1'b0);
    send_word('1, 1'b1);
    send_word('0, 1'b1);
    send_message(TYPE_REQUEST_CTX, '0, 4'd0, 1'b1, 10'h001, 1'b1);
    settle();
  endtask

  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    hold_req = 300;
    repeat (6) send_message(TYPE_REQUEST, 16'hFFFF, 4'd0, 1'b0, '0, 1'b1);
    repeat (3) send_message(TYPE_REQUEST_CTX, '0, 4'd0, 1'b0, '0, 1'b1);
    settle();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic test_random_buffers();
    int unsigned at, len, pick;
    logic [15:0] mtype, counts;
    logic [3:0] flags;
    while (sent_words < ITEM_TARGET) begin
      gaps_on = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        repeat ($urandom_range(1, 12)) send_word($urandom, $urandom_range(0, 7) == 0);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: mtype = TYPE_REQUEST;
          3, 4, 5: mtype = TYPE_REQUEST_CTX;
          6:       mtype = TYPE_CLOSE;
          7:       mtype = TYPE_CLOSE_ALT;
          8:       mtype = 16'($urandom);
          default: mtype = 16'($urandom_range(0, 16));
        endcase
        if ($urandom_range(0, 7) == 0) begin
          counts = 16'($urandom);
        end else begin
          counts = {4'($urandom_range(0, 2)), 4'($urandom_range(0, 2)),
                    4'($urandom_range(0, 3)), 4'($urandom_range(0, 4))};
        end
        flags = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
        at = compose_buffer(mtype, counts, flags, $urandom_range(0, 1) == 1,
                            10'($urandom), $urandom_range(0, 7) != 0);
        len = at + 1 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
        if (pick == 1) len = $urandom_range(1, at);
        if (len > BUF_WORDS) len = BUF_WORDS;
        send_buffer(len);
      end
    end
    settle();
  endtask

  initial begin : receiver
    int unsigned pause;
    out_stall_i = 1'b0;
    pause = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_req) @(posedge clk_i);
        hold_req = 0;
        pause = 0;
        out_stall_i <= 1'b0;
      end else if (out_valid_o && !out_stall_i) begin
        pause = stalls_on ? $urandom_range(0, 16) : 0;
        out_stall_i <= (pause != 0);
      end else if (pause != 0) begin
        pause--;
        out_stall_i <= (pause != 0);
      end
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : header_check
    header_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (headers_due.size() == 0) begin
        $error("header transfer with none pending, status %0d", status_o);
        errors++;
      end else begin
        want = headers_due.pop_front();
        check_field("status", want.status, status_o);
        check_field("msg_type", want.msg_type, msg_type_o);
        check_field("cmd_word", want.cmd_word, cmd_word_o);
        check_field("pid_req", want.pid_req, pid_req_o);
        check_field("caller_pid", want.caller_pid, caller_pid_o);
        check_field("copy_hnd", want.copy_hnd, copy_hnd_o);
        check_field("move_hnd", want.move_hnd, move_hnd_o);
        check_field("handle_offset", want.handle_offset, handle_offset_o);
        check_field("raw_offset", want.raw_offset, raw_offset_o);
        check_field("body_len", want.body_len, body_len_o);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    word_i = '0;
    start_req_i = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_idle_after_reset();
    test_message_types();
    test_handle_descriptor();
    test_walk_bounds();
    test_restart();
    test_output_backpressure();
    test_random_buffers();
    settle();
    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
